@@ hw/rtl/switch_mode_led_blink_controller_assert.svh @@
// Assertion macros for the switch-mode LED blink controller checker.
// No dependencies; included by the checker file.
`ifndef SWITCH_MODE_LED_BLINK_CONTROLLER_ASSERT_SVH
`define SWITCH_MODE_LED_BLINK_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SLBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SLBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/slbc_pkg.sv @@
// Shared types and constants for the switch-mode LED blink controller.
// No dependencies; used by every module of the block.
package slbc_pkg;

  // Default ADC width
  localparam int ADC_BITS_DEF = 12;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_LED3_HALF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LED1_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT   = 2'd2;

  // Register reset values
  localparam logic [6:0] LED3_HALF_RST = 7'd50;
  localparam logic [6:0] LED1_BASE_RST = 7'd100;
  localparam logic [3:0] LOCKOUT_RST   = 4'd5;

  // Result word
  localparam int OUT_W = 8;

  // LED1 phase codes
  localparam logic [1:0] PH_OFF   = 2'd0;
  localparam logic [1:0] PH_STEP  = 2'd1;
  localparam logic [1:0] PH_BLINK = 2'd2;

  // Blink counter verdict
  typedef enum logic [1:0] {
    BLINK_DARK,
    BLINK_LIGHT,
    BLINK_KEEP
  } blink_act_t;

  // Per-tick control for one blink counter
  typedef struct packed {
    logic step;   // advance the counter
    logic clear;  // force it to zero
  } blink_ctl_t;

endpackage

@@ hw/rtl/slbc_blink.sv @@
// Blink counter: counts ticks over an on and an off half, then rests one tick.
// Depends on slbc_pkg.
module slbc_blink #(
  parameter int W = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  slbc_pkg::blink_ctl_t    ctl,
  input  logic [W-1:0]            half,
  input  logic [W-1:0]            full,
  output slbc_pkg::blink_act_t    act
);

  logic [W-1:0] cnt_r;
  logic [W-1:0] cnt_nxt;
  logic [W-1:0] cnt_inc;

  // Verdict for the incremented count; a count left above a shrunk full
  // falls to the rest tick, and W leaves room so the increment never wraps
  always_comb begin
    cnt_inc = cnt_r + W'(1);
    if (cnt_inc <= half) begin
      act = slbc_pkg::BLINK_LIGHT;
    end else if (cnt_inc <= full) begin
      act = slbc_pkg::BLINK_DARK;
    end else begin
      act = slbc_pkg::BLINK_KEEP;
    end
    cnt_nxt = (act == slbc_pkg::BLINK_KEEP) ? '0 : cnt_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.clear) begin
      cnt_r <= '0;
    end else if (ctl.step) begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hw/rtl/switch_mode_led_blink_controller.sv @@
// Top level of the switch-mode LED blink controller: state, debounce, result register.
// Depends on slbc_pkg and slbc_blink.
//
//  channel | dir | width            | contents
//  in_     | in  | bytes(ADC_BITS+2) | raw_switch_one, raw_switch_two, adc_level
//  out_    | out | 8                | led_one, led_two, led_three, led_one_mode
//  cfg_    | in  | 2 + 7            | register index, write data
//
// One word per cycle while the result is taken; the result appears in the cycle
// after the word is taken. The whole tick is computed in one pass from the input
// word and the state registers, and lands in the result register.
// rst_n is synchronous: all state but the result payload returns to its reset values.
// A stalled result holds; a new word is still taken when the result is taken
// in the same cycle.
module switch_mode_led_blink_controller #(
  parameter int ADC_BITS = slbc_pkg::ADC_BITS_DEF,
  localparam int IN_W = ((ADC_BITS + 2 + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [0] raw_switch_one, [1] raw_switch_two, [ADC_BITS+1:2] adc_level, rest zero
  input  logic [IN_W-1:0]                  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] led_one, [1] led_two, [2] led_three, [4:3] led_one_mode, [7:5] zero
  output logic [slbc_pkg::OUT_W-1:0]       out_tdata,
  input  logic                             cfg_we,
  input  logic [slbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slbc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int L3_W = 8;
  localparam int L1_W = 9;
  localparam int L2_W = ADC_BITS + 1;

  // Configuration registers
  logic [6:0] led3_half_r;
  logic [6:0] led1_base_r;
  logic [3:0] lockout_r;

  // Tick state
  logic       sw1_db_r, sw1_db_nxt;
  logic       sw2_db_r, sw2_db_nxt;
  logic       lock_act_r, lock_act_nxt;
  logic [3:0] lock_cnt_r, lock_cnt_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [1:0] mode_r, mode_nxt;     // rate divider 0,1,2,4 kept as 0..3
  logic [2:0] led_r, led_nxt;       // [0] LED1, [1] LED2, [2] LED3

  // Result stage
  logic                       out_valid_r;
  logic [slbc_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  logic                  fire;
  logic                  sw1_raw, sw2_raw;
  logic [ADC_BITS-1:0]   adc;
  logic [6:0]            l1_half;
  logic [1:0]            l1_shift;
  logic                  l1_run, l1_clr;
  logic                  accept1, lock_mid, accept2, lock_any;
  logic [3:0]            lock_inc;

  slbc_pkg::blink_ctl_t  l3_ctl, l1_ctl, l2_ctl;
  slbc_pkg::blink_act_t  l3_act, l1_act, l2_act;

  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;
  assign sw1_raw   = in_tdata[0];
  assign sw2_raw   = in_tdata[1];
  assign adc       = in_tdata[ADC_BITS+1:2];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led3_half_r <= slbc_pkg::LED3_HALF_RST;
      led1_base_r <= slbc_pkg::LED1_BASE_RST;
      lockout_r   <= slbc_pkg::LOCKOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        slbc_pkg::REG_LED3_HALF: led3_half_r <= cfg_wdata;
        slbc_pkg::REG_LED1_BASE: led1_base_r <= cfg_wdata;
        slbc_pkg::REG_LOCKOUT:   lockout_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // LED1 half period: base shifted by the divider
  assign l1_shift = (mode_r == 2'd0) ? 2'd0 : mode_r - 2'd1;
  assign l1_half  = led1_base_r >> l1_shift;

  // LED1 counter runs while blinking, or while held with a nonzero divider
  always_comb begin
    l1_run = 1'b0;
    l1_clr = 1'b0;
    if (sw1_db_r) begin
      l1_run = (phase_r == slbc_pkg::PH_BLINK);
    end else if (mode_r == 2'd0) begin
      l1_clr = 1'b1;
    end else begin
      l1_run = 1'b1;
    end
  end

  assign l3_ctl = '{step: fire, clear: 1'b0};
  assign l1_ctl = '{step: fire && l1_run, clear: fire && l1_clr};
  assign l2_ctl = '{step: fire && !sw2_db_r, clear: fire && sw2_db_r};

  slbc_blink #(.W(L3_W)) u_led3 (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (l3_ctl),
    .half  (L3_W'(led3_half_r)),
    .full  (L3_W'({led3_half_r, 1'b0})),
    .act   (l3_act)
  );

  slbc_blink #(.W(L1_W)) u_led1 (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (l1_ctl),
    .half  (L1_W'(l1_half)),
    .full  (L1_W'({l1_half, 1'b0})),
    .act   (l1_act)
  );

  slbc_blink #(.W(L2_W)) u_led2 (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (l2_ctl),
    .half  (L2_W'(adc >> 1)),
    .full  (L2_W'(adc)),
    .act   (l2_act)
  );

  function automatic logic apply_act(logic level, slbc_pkg::blink_act_t act);
    logic res;
    case (act)
      slbc_pkg::BLINK_LIGHT: res = 1'b1;
      slbc_pkg::BLINK_DARK:  res = 1'b0;
      default:               res = level;
    endcase
    return res;
  endfunction

  // LED update for one tick
  always_comb begin
    led_nxt    = led_r;
    phase_nxt  = phase_r;
    mode_nxt   = mode_r;
    led_nxt[2] = apply_act(led_r[2], l3_act);

    if (sw1_db_r) begin
      unique case (phase_r)
        slbc_pkg::PH_OFF: led_nxt[0] = 1'b0;
        slbc_pkg::PH_STEP: begin
          mode_nxt  = mode_r + 2'd1;
          phase_nxt = (mode_r == 2'd3) ? slbc_pkg::PH_OFF : slbc_pkg::PH_BLINK;
        end
        slbc_pkg::PH_BLINK: led_nxt[0] = apply_act(led_r[0], l1_act);
        default: ;
      endcase
    end else begin
      phase_nxt  = slbc_pkg::PH_STEP;
      led_nxt[0] = (mode_r == 2'd0) ? 1'b0 : apply_act(led_r[0], l1_act);
    end

    led_nxt[1] = sw2_db_r ? 1'b0 : apply_act(led_r[1], l2_act);
  end

  // Debounce with a shared lockout; switch 1 has priority
  always_comb begin
    accept1      = (sw1_raw != sw1_db_r) && !lock_act_r;
    lock_mid     = lock_act_r || accept1;
    accept2      = (sw2_raw != sw2_db_r) && !lock_mid;
    lock_any     = lock_mid || accept2;
    sw1_db_nxt   = accept1 ? sw1_raw : sw1_db_r;
    sw2_db_nxt   = accept2 ? sw2_raw : sw2_db_r;
    lock_inc     = lock_cnt_r + 4'd1;
    lock_act_nxt = lock_any;
    lock_cnt_nxt = lock_cnt_r;
    if (lock_any) begin
      if (lock_inc == lockout_r) begin
        lock_act_nxt = 1'b0;
        lock_cnt_nxt = 4'd0;
      end else begin
        lock_cnt_nxt = lock_inc;
      end
    end
  end

  assign out_data_nxt = {3'b000, mode_nxt, led_nxt};

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw1_db_r    <= 1'b1;
      sw2_db_r    <= 1'b1;
      lock_act_r  <= 1'b0;
      lock_cnt_r  <= 4'd0;
      phase_r     <= slbc_pkg::PH_OFF;
      mode_r      <= 2'd0;
      led_r       <= 3'b000;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        sw1_db_r   <= sw1_db_nxt;
        sw2_db_r   <= sw2_db_nxt;
        lock_act_r <= lock_act_nxt;
        lock_cnt_r <= lock_cnt_nxt;
        phase_r    <= phase_nxt;
        mode_r     <= mode_nxt;
        led_r      <= led_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ hw/rtl/slbc_checker.sv @@
// Port-level checker for the switch-mode LED blink controller, bound to the top.
// Depends on slbc_pkg and switch_mode_led_blink_controller_assert.svh.
`include "switch_mode_led_blink_controller_assert.svh"

module slbc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [slbc_pkg::OUT_W-1:0] out_tdata
);

  // Nothing is pending straight after reset
  `SLBC_ASSERT_NOW(a_idle_after_rst, $past(!rst_n), !out_tvalid, "result valid after reset")

  // Empty result stage must take a word
  `SLBC_ASSERT_NOW(a_ready_when_empty, !out_tvalid, in_tready, "not ready with empty result")

  // Every taken word gives a result next cycle
  `SLBC_ASSERT_NEXT(a_word_to_result, in_tvalid && in_tready, out_tvalid, "taken word lost")

  // Pad bits of a result stay zero
  `SLBC_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[7:5] == 3'b000, "result pad bits set")

  // Stalled result holds
  `SLBC_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind switch_mode_led_blink_controller slbc_checker u_slbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ bench/switch_mode_led_blink_controller_tb.sv @@
`timescale 1ns / 100ps
// Testbench for switch_mode_led_blink_controller: directed and random ticks through the
// in_ stream, every out_ word checked against a tick-level predictor of the LED logic.
// Depends on slbc_pkg and the block's RTL.
module switch_mode_led_blink_controller_tb;

  localparam int ADC_W        = slbc_pkg::ADC_BITS_DEF;
  localparam int IN_W         = ((ADC_W + 2 + 7) / 8) * 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASES       = 8;
  localparam int PHASE_TICKS  = 228;
  // index with no register behind it
  localparam logic [slbc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // in_tdata fields, lowest bit first from the bottom of the struct
  typedef struct packed {
    logic [ADC_W-1:0] adc_level;
    logic             raw_switch_two;
    logic             raw_switch_one;
  } tick_t;

  // out_tdata[4:0]
  typedef struct packed {
    logic [1:0] led_one_mode;
    logic       led_three;
    logic       led_two;
    logic       led_one;
  } leds_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [IN_W-1:0]                 in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [slbc_pkg::OUT_W-1:0]      out_tdata;
  logic                            cfg_we = 1'b0;
  logic [slbc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [slbc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  switch_mode_led_blink_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  tick_t tick_queue[$];
  leds_t expected_leds[$];
  int    mismatches = 0;
  int    cycles = 0;
  logic  in_word_taken = 1'b0;
  logic  out_word_taken = 1'b0;

  // Predictor state: registers
  logic [6:0] p_led3_half, p_led1_base;
  logic [3:0] p_lock_len;
  // Predictor state: debounce, counters, LED1 sequencer
  logic        p_sw1, p_sw2, p_lock_on;
  logic [3:0]  p_lock_cnt;
  int unsigned p_cnt3, p_cnt1, p_cnt2, p_div;
  logic [1:0]  p_phase;
  logic        p_led1, p_led2, p_led3;

  // Switch and ADC generator state
  logic             gen_sw1 = 1'b1, gen_sw2 = 1'b1;
  logic [ADC_W-1:0] gen_adc = '0;
  int unsigned      run1 = 0, run2 = 0, run_adc = 0;

  // Clock
  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void predictor_reset();
    p_led3_half = slbc_pkg::LED3_HALF_RST;
    p_led1_base = slbc_pkg::LED1_BASE_RST;
    p_lock_len  = slbc_pkg::LOCKOUT_RST;
    p_sw1 = 1'b1;
    p_sw2 = 1'b1;
    p_lock_on = 1'b0;
    p_lock_cnt = '0;
    p_cnt3 = 0;
    p_cnt1 = 0;
    p_cnt2 = 0;
    p_div = 0;
    p_phase = slbc_pkg::PH_OFF;
    p_led1 = 1'b0;
    p_led2 = 1'b0;
    p_led3 = 1'b0;
  endfunction

  // Counter already advanced: lit up to half, dark up to 2*half, then wrap
  function automatic slbc_pkg::blink_act_t blink_verdict(int unsigned cnt, int unsigned half);
    if (cnt <= half) return slbc_pkg::BLINK_LIGHT;
    if (cnt <= 2 * half) return slbc_pkg::BLINK_DARK;
    return slbc_pkg::BLINK_KEEP;
  endfunction

  function automatic logic led_after(slbc_pkg::blink_act_t act, logic cur);
    case (act)
      slbc_pkg::BLINK_LIGHT: return 1'b1;
      slbc_pkg::BLINK_DARK:  return 1'b0;
      default:               return cur;
    endcase
  endfunction

  // LED1 half period is the base shifted down by the divider
  function automatic void led1_blink();
    int unsigned          half;
    slbc_pkg::blink_act_t act;
    half = (p_div != 0) ? p_led1_base / p_div : p_led1_base;
    p_cnt1++;
    act = blink_verdict(p_cnt1, half);
    if (act == slbc_pkg::BLINK_KEEP) p_cnt1 = 0;
    p_led1 = led_after(act, p_led1);
  endfunction

  function automatic leds_t predict_tick(tick_t t);
    slbc_pkg::blink_act_t act;
    leds_t                r;
    // LED3, free running
    p_cnt3++;
    act = blink_verdict(p_cnt3, p_led3_half);
    if (act == slbc_pkg::BLINK_KEEP) p_cnt3 = 0;
    p_led3 = led_after(act, p_led3);
    // LED1 sequencer, stepped on release of switch 1
    if (p_sw1) begin
      case (p_phase)
        slbc_pkg::PH_OFF: p_led1 = 1'b0;
        slbc_pkg::PH_STEP: begin
          if (p_div == 0) begin
            p_div = 1;
            p_phase = slbc_pkg::PH_BLINK;
          end else if (p_div < 4) begin
            p_div = p_div * 2;
            p_phase = slbc_pkg::PH_BLINK;
          end else begin
            p_div = 0;
            p_phase = slbc_pkg::PH_OFF;
          end
        end
        slbc_pkg::PH_BLINK: led1_blink();
        default: ;
      endcase
    end else begin
      p_phase = slbc_pkg::PH_STEP;
      if (p_div == 0) begin
        p_led1 = 1'b0;
        p_cnt1 = 0;
      end else begin
        led1_blink();
      end
    end
    // LED2 while switch 2 held: lit up to adc/2, dark up to adc, then wrap
    if (p_sw2) begin
      p_led2 = 1'b0;
      p_cnt2 = 0;
    end else begin
      p_cnt2++;
      if (p_cnt2 <= t.adc_level / 2) begin
        act = slbc_pkg::BLINK_LIGHT;
      end else if (p_cnt2 <= t.adc_level) begin
        act = slbc_pkg::BLINK_DARK;
      end else begin
        act = slbc_pkg::BLINK_KEEP;
        p_cnt2 = 0;
      end
      p_led2 = led_after(act, p_led2);
    end
    // Debounce with shared lockout; switch 1 wins a tie
    if (t.raw_switch_one != p_sw1 && !p_lock_on) begin
      p_sw1 = t.raw_switch_one;
      p_lock_on = 1'b1;
    end
    if (t.raw_switch_two != p_sw2 && !p_lock_on) begin
      p_sw2 = t.raw_switch_two;
      p_lock_on = 1'b1;
    end
    if (p_lock_on) begin
      p_lock_cnt = p_lock_cnt + 4'd1;
      if (p_lock_cnt == p_lock_len) begin
        p_lock_on = 1'b0;
        p_lock_cnt = '0;
      end
    end
    r.led_one = p_led1;
    r.led_two = p_led2;
    r.led_three = p_led3;
    case (p_div)
      0: r.led_one_mode = 2'd0;
      1: r.led_one_mode = 2'd1;
      2: r.led_one_mode = 2'd2;
      default: r.led_one_mode = 2'd3;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: config mirror, result check, then prediction for the word just taken
  always @(posedge clk) begin : monitor
    leds_t want, got;
    in_word_taken = rst_n && in_tvalid && in_tready;
    out_word_taken = rst_n && out_tvalid && out_tready;
    if (!rst_n) begin
      predictor_reset();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          slbc_pkg::REG_LED3_HALF: p_led3_half = cfg_wdata[6:0];
          slbc_pkg::REG_LED1_BASE: p_led1_base = cfg_wdata[6:0];
          slbc_pkg::REG_LOCKOUT:   p_lock_len = cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (out_word_taken) begin
        if (expected_leds.size() == 0) begin
          $display("%0t: result word expected none actual %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = expected_leds.pop_front();
          got = out_tdata[4:0];
          check_field("led_one", want.led_one, got.led_one);
          check_field("led_two", want.led_two, got.led_two);
          check_field("led_three", want.led_three, got.led_three);
          check_field("led_one_mode", want.led_one_mode, got.led_one_mode);
          check_field("pad bits", 0, out_tdata[slbc_pkg::OUT_W-1:5]);
        end
      end
      if (in_word_taken) begin
        expected_leds.push_back(predict_tick(tick_t'(in_tdata[$bits(tick_t)-1:0])));
      end
    end
  end

  // Input driver: one word at a time from tick_queue, random gap before each
  always @(negedge clk) begin : in_driver
    int unsigned in_gap;
    logic        in_burst;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
      in_burst = 1'b0;
    end else if (!in_tvalid || in_word_taken) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (tick_queue.size() != 0) begin
        in_tdata <= {{(IN_W - $bits(tick_t)){1'b0}}, tick_queue.pop_front()};
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 79) == 0) in_burst = ~in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 4);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side: random stall after each word taken
  always @(negedge clk) begin : out_stall
    int unsigned out_wait;
    logic        out_burst;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait = 0;
      out_burst = 1'b0;
    end else begin
      if (out_word_taken) begin
        if ($urandom_range(0, 79) == 0) out_burst = ~out_burst;
        out_wait = out_burst ? 0 : $urandom_range(0, 4);
      end
      if (out_wait > 0) begin
        out_tready <= 1'b0;
        out_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_tick(logic s1, logic s2, logic [ADC_W-1:0] adc, int n);
    tick_t t;
    t.raw_switch_one = s1;
    t.raw_switch_two = s2;
    t.adc_level = adc;
    repeat (n) tick_queue.push_back(t);
  endtask

  // Held switch levels with random run lengths, some bounce noise
  task automatic queue_ticks(int n);
    tick_t t;
    for (int i = 0; i < n; i++) begin
      if (run1 == 0) begin
        gen_sw1 = ~gen_sw1;
        run1 = $urandom_range(1, 25);
      end else run1--;
      if (run2 == 0) begin
        gen_sw2 = ~gen_sw2;
        run2 = $urandom_range(1, 40);
      end else run2--;
      if (run_adc == 0) begin
        case ($urandom_range(0, 9))
          0, 1: gen_adc = ADC_W'($urandom_range(0, 4095));
          2: gen_adc = $urandom_range(0, 1) ? 12'hFFF : ADC_W'($urandom_range(0, 2));
          default: gen_adc = ADC_W'($urandom_range(0, 40));
        endcase
        run_adc = $urandom_range(5, 60);
      end else run_adc--;
      t.raw_switch_one = gen_sw1;
      t.raw_switch_two = gen_sw2;
      t.adc_level = gen_adc;
      if ($urandom_range(0, 9) == 0) begin
        t.raw_switch_one = 1'($urandom_range(0, 1));
        t.raw_switch_two = 1'($urandom_range(0, 1));
        t.adc_level = ADC_W'($urandom_range(0, 4095));
      end
      tick_queue.push_back(t);
    end
  endtask

  task automatic wait_idle();
    while (tick_queue.size() != 0 || in_tvalid || expected_leds.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [slbc_pkg::CFG_IDX_W-1:0] idx,
                           logic [slbc_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  // Stimulus
  initial begin
    logic [slbc_pkg::CFG_DATA_W-1:0] led3_val, led1_val, lock_val;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset register values
    push_tick(1'b1, 1'b1, 12'h000, 1);
    push_tick(1'b1, 1'b1, 12'hFFF, 1);
    push_tick(1'b0, 1'b0, 12'd3, 6);      // both switches move on one tick
    push_tick(1'b1, 1'b0, 12'd3, 6);      // release 1, taken after switch 2's lockout
    push_tick(1'b1, 1'b0, 12'h000, 3);    // zero ADC period holds LED2
    push_tick(1'b1, 1'b0, 12'hFFF, 2);
    push_tick(1'b0, 1'b1, 12'hAAA, 2);    // bounce inside lockout
    push_tick(1'b1, 1'b1, 12'h555, 3);
    queue_ticks(PHASE_TICKS);

    for (int p = 1; p < PHASES; p++) begin
      wait_idle();
      case (p)
        1: begin led3_val = 7'd1;   led1_val = 7'd1;   lock_val = 7'd1;  end
        2: begin led3_val = 7'd127; led1_val = 7'd127; lock_val = 7'd15; end
        3: begin led3_val = 7'd0;   led1_val = 7'd0;   lock_val = 7'd0;  end
        4: begin led3_val = 7'd3;   led1_val = 7'd12;  lock_val = 7'd2;  end
        5: begin led3_val = 7'd7;   led1_val = 7'd40;  lock_val = 7'h73; end
        default: begin
          led3_val = 7'($urandom_range(1, 20));
          led1_val = 7'($urandom_range(1, 60));
          lock_val = 7'($urandom_range(0, 127));
        end
      endcase
      write_reg(slbc_pkg::REG_LED3_HALF, led3_val);
      write_reg(slbc_pkg::REG_LED1_BASE, led1_val);
      write_reg(slbc_pkg::REG_LOCKOUT, lock_val);
      write_reg(REG_SPARE, 7'($urandom_range(0, 127)));
      @(negedge clk);
      cfg_we <= 1'b0;
      queue_ticks(PHASE_TICKS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ switch_mode_led_blink_controller.f @@
+incdir+hw/rtl
hw/rtl/slbc_pkg.sv
hw/rtl/slbc_blink.sv
hw/rtl/switch_mode_led_blink_controller.sv
hw/rtl/slbc_checker.sv
bench/switch_mode_led_blink_controller_tb.sv
